@@ src/q2e_pkg.sv @@
//------------------------------------------------------------------------------
// q2e_pkg
// Shared widths and the CORDIC arctangent table for the quaternion converter.
//------------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;
	localparam int SUM_W  = 34;
	localparam int SP_W   = 31;
	localparam int REM_W  = 62;
	localparam int SQRT_STEPS = 31;
	localparam int ROOT_W = 31;
	localparam int CW     = 36;
	localparam int ZW     = 25;
	localparam int RW     = 18;
	localparam logic signed [ZW-1:0] ANG_PI_Q20  = 25'sd3294199;
	localparam logic signed [RW-1:0] PI_Q13      = 18'sd25736;
	localparam logic signed [RW-1:0] HALF_PI_Q13 = 18'sd12868;

	function automatic logic signed [ZW-1:0] atan_q20(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 25'sd823550;
			1: a = 25'sd486170;
			2: a = 25'sd256879;
			3: a = 25'sd130396;
			4: a = 25'sd65451;
			5: a = 25'sd32757;
			6: a = 25'sd16383;
			7: a = 25'sd8192;
			8: a = 25'sd4096;
			9: a = 25'sd2048;
			10: a = 25'sd1024;
			11: a = 25'sd512;
			12: a = 25'sd256;
			13: a = 25'sd128;
			14: a = 25'sd64;
			15: a = 25'sd32;
			16: a = 25'sd16;
			17: a = 25'sd8;
			18: a = 25'sd4;
			19: a = 25'sd2;
			20: a = 25'sd1;
			21: a = 25'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

@@ src/q2e_front.sv @@
//------------------------------------------------------------------------------
// q2e_front
// Products, sine/cosine terms, pitch clamp test and 1 - sp^2 in three stages.
//------------------------------------------------------------------------------
`default_nettype none
module q2e_front (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [15:0]                quat_w,
	input  wire logic signed [15:0]                quat_x,
	input  wire logic signed [15:0]                quat_y,
	input  wire logic signed [15:0]                quat_z,
	output logic        [q2e_pkg::REM_W-1:0]       rem,
	output logic signed [q2e_pkg::SUM_W-1:0]       sy,
	output logic signed [q2e_pkg::SUM_W-1:0]       cy,
	output logic signed [q2e_pkg::SUM_W-1:0]       sr,
	output logic signed [q2e_pkg::SUM_W-1:0]       cr,
	output logic signed [q2e_pkg::SP_W-1:0]        sp,
	output logic                                   clamp,
	output logic                                   pos
);
	localparam int SW = q2e_pkg::SUM_W;
	localparam int PW = q2e_pkg::SP_W;

	logic signed [31:0] wy_s1, zx_s1, yy_s1, xx_s1, wx_s1, yz_s1, wz_s1, xy_s1, zz_s1;
	logic signed [SW-1:0] sy_c, cy_c, sp_c, sr_c, cr_c;
	logic signed [SW-1:0] sy_s2, cy_s2, sr_s2, cr_s2;
	logic signed [PW-1:0] sp_s2;
	logic clamp_s2, pos_s2;
	logic [2*PW-1:0] sq_c;

	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
			yy_s1 <= quat_y * quat_y;
			xx_s1 <= quat_x * quat_x;
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			zz_s1 <= quat_z * quat_z;
		end
	end

	localparam logic signed [SW-1:0] ONE = SW'(64'sd1 <<< 30);

	always_comb begin
		sy_c = (SW'(wy_s1) + SW'(zx_s1)) <<< 1;
		cy_c = ONE - ((SW'(yy_s1) + SW'(xx_s1)) <<< 1);
		sp_c = (SW'(wx_s1) - SW'(yz_s1)) <<< 1;
		sr_c = (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
		cr_c = ONE - ((SW'(zz_s1) + SW'(xx_s1)) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sy_s2    <= sy_c;
			cy_s2    <= cy_c;
			sr_s2    <= sr_c;
			cr_s2    <= cr_c;
			clamp_s2 <= (sp_c >= ONE) || (sp_c <= -ONE);
			pos_s2   <= (sp_c > 0);
			sp_s2    <= ((sp_c >= ONE) || (sp_c <= -ONE)) ? '0 : sp_c[PW-1:0];
		end
	end

	assign sq_c = $unsigned((2*PW)'(sp_s2) * (2*PW)'(sp_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			rem   <= (q2e_pkg::REM_W'(1) << 60) - q2e_pkg::REM_W'(sq_c);
			sy    <= sy_s2;
			cy    <= cy_s2;
			sr    <= sr_s2;
			cr    <= cr_s2;
			sp    <= sp_s2;
			clamp <= clamp_s2;
			pos   <= pos_s2;
		end
	end
endmodule
`default_nettype wire

@@ src/q2e_isqrt.sv @@
//------------------------------------------------------------------------------
// q2e_isqrt
// Pipelined bitwise integer square root, one result bit per stage.
//------------------------------------------------------------------------------
`default_nettype none
module q2e_isqrt #(
	parameter int SIDE_W = 8
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [q2e_pkg::REM_W-1:0]       n_in,
	input  wire logic [SIDE_W-1:0]               side_in,
	output logic      [q2e_pkg::ROOT_W-1:0]      root,
	output logic      [SIDE_W-1:0]               side_out
);
	localparam int N  = q2e_pkg::SQRT_STEPS;
	localparam int RW = q2e_pkg::REM_W;

	logic [RW-1:0]     n_s [N];
	logic [RW-1:0]     r_s [N];
	logic [SIDE_W-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW-1:0] n_i, r_i, t;
		localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2*k);
		if (k == 0) begin : g_first
			assign n_i = n_in;
			assign r_i = '0;
		end else begin : g_next
			assign n_i = n_s[k-1];
			assign r_i = r_s[k-1];
		end
		assign t = r_i + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (n_i >= t) begin
					n_s[k] <= n_i - t;
					r_s[k] <= (r_i >> 1) + BIT;
				end else begin
					n_s[k] <= n_i;
					r_s[k] <= r_i >> 1;
				end
				side_s[k] <= (k == 0) ? side_in : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign root     = r_s[N-1][q2e_pkg::ROOT_W-1:0];
	assign side_out = side_s[N-1];
endmodule
`default_nettype wire

@@ src/q2e_cordic.sv @@
//------------------------------------------------------------------------------
// q2e_cordic
// Vectoring CORDIC atan2 pipeline: pre-rotation stage, then one stage per step.
//------------------------------------------------------------------------------
`default_nettype none
module q2e_cordic #(
	parameter int STEPS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [q2e_pkg::CW-1:0]  sin_in,
	input  wire logic signed [q2e_pkg::CW-1:0]  cos_in,
	output logic signed [q2e_pkg::ZW-1:0]       angle
);
	localparam int CW = q2e_pkg::CW;
	localparam int ZW = q2e_pkg::ZW;

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic signed [ZW-1:0] z_s [STEPS+1];
	logic                 zf_s [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zf_s[0] <= (sin_in == 0) && (cos_in == 0);
			if (cos_in < 0) begin
				x_s[0] <= -cos_in;
				y_s[0] <= -sin_in;
				z_s[0] <= (sin_in >= 0) ? q2e_pkg::ANG_PI_Q20 : -q2e_pkg::ANG_PI_Q20;
			end else begin
				x_s[0] <= cos_in;
				y_s[0] <= sin_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] A = q2e_pkg::atan_q20(i);
		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= zf_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + A;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - A;
				end
			end
		end
	end

	assign angle = zf_s[STEPS] ? '0 : z_s[STEPS];
endmodule
`default_nettype wire

@@ src/quaternion_to_euler.sv @@
//------------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion (Q1.15) to yaw/pitch/roll (Q3.13 rad), Y-X-Z order.
//------------------------------------------------------------------------------
// Input channel: in_valid/in_stall with quat_w..quat_z. Output channel:
// out_valid/out_stall with yaw_angle, pitch_angle, roll_angle, pitch_clamped.
// An item moves at a clock edge where valid is high and stall is low.
// Throughput: one item per cycle while the output is not stalled, no gaps between independent items.
// Stages in order: 16-bit products, term sums, 1 - sp^2, 31 square-root
// stages, CORDIC pre-rotation plus CORDIC_STEPS iterations, rounding/saturation.
// The square root and CORDIC stage chains are the longest parts of the pipeline.
// Reset (arst_n low) empties the pipeline: all valid bits clear, out_valid
// drops. While out_valid is high and out_stall is high the whole pipeline
// holds and in_stall is raised; nothing is lost or repeated.
//------------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] quat_w,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      yaw_angle,
	output logic signed [14:0]      pitch_angle,
	output logic signed [15:0]      roll_angle,
	output logic                    pitch_clamped
);
	localparam int LAT = 36 + CORDIC_STEPS;
	localparam int SW  = q2e_pkg::SUM_W;
	localparam int PW  = q2e_pkg::SP_W;
	localparam int CW  = q2e_pkg::CW;
	localparam int ZW  = q2e_pkg::ZW;
	localparam int RW  = q2e_pkg::RW;
	localparam int SIDE_W = 4*SW + PW + 2;
	localparam int FLAG_LAT = CORDIC_STEPS + 1;

	logic en;
	logic [LAT-1:0] v_q;

	assign en       = !(v_q[LAT-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	assign out_valid = v_q[LAT-1];

	logic [q2e_pkg::REM_W-1:0] rem;
	logic signed [SW-1:0] sy, cy, sr, cr;
	logic signed [PW-1:0] sp;
	logic clamp, pos;

	q2e_front u_front (
		.clk(clk), .en(en),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.rem(rem), .sy(sy), .cy(cy), .sr(sr), .cr(cr), .sp(sp),
		.clamp(clamp), .pos(pos)
	);

	logic [q2e_pkg::ROOT_W-1:0] root;
	logic [SIDE_W-1:0] side_d;
	logic signed [SW-1:0] sy_d, cy_d, sr_d, cr_d;
	logic signed [PW-1:0] sp_d;
	logic clamp_d, pos_d;

	q2e_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
		.clk(clk), .en(en), .n_in(rem),
		.side_in({sy, cy, sr, cr, sp, clamp, pos}),
		.root(root), .side_out(side_d)
	);

	assign {sy_d, cy_d, sr_d, cr_d, sp_d, clamp_d, pos_d} = side_d;

	logic signed [ZW-1:0] yaw_z, pitch_z, roll_z;

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(en), .sin_in(CW'(sy_d)), .cos_in(CW'(cy_d)), .angle(yaw_z)
	);
	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(en), .sin_in(CW'(sp_d)),
		.cos_in($signed({{(CW-q2e_pkg::ROOT_W){1'b0}}, root})), .angle(pitch_z)
	);
	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(en), .sin_in(CW'(sr_d)), .cos_in(CW'(cr_d)), .angle(roll_z)
	);

	logic [1:0] flag_s [FLAG_LAT];
	always_ff @(posedge clk) begin
		if (en) begin
			flag_s[0] <= {clamp_d, pos_d};
			for (int k = 1; k < FLAG_LAT; k++) flag_s[k] <= flag_s[k-1];
		end
	end

	function automatic logic signed [RW-1:0] round_sat(input logic signed [ZW-1:0] a,
			input logic signed [RW-1:0] lim);
		logic signed [ZW-1:0] t;
		logic signed [RW-1:0] r;
		t = (a + ZW'(64)) >>> 7;
		r = t[RW-1:0];
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	logic signed [RW-1:0] yaw_r, pitch_r, roll_r;
	always_comb begin
		yaw_r  = round_sat(yaw_z, q2e_pkg::PI_Q13);
		roll_r = round_sat(roll_z, q2e_pkg::PI_Q13);
		if (flag_s[FLAG_LAT-1][1]) begin
			pitch_r = flag_s[FLAG_LAT-1][0] ? q2e_pkg::HALF_PI_Q13 : -q2e_pkg::HALF_PI_Q13;
		end else begin
			pitch_r = round_sat(pitch_z, q2e_pkg::HALF_PI_Q13);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_angle     <= yaw_r[15:0];
			pitch_angle   <= pitch_r[14:0];
			roll_angle    <= roll_r[15:0];
			pitch_clamped <= flag_s[FLAG_LAT-1][1];
		end
	end
endmodule
`default_nettype wire

@@ src/q2e_checker.sv @@
//------------------------------------------------------------------------------
// q2e_checker
// Port-level checks for quaternion_to_euler, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
module q2e_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] yaw_angle,
	input wire logic signed [14:0] pitch_angle,
	input wire logic signed [15:0] roll_angle,
	input wire logic               pitch_clamped
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(yaw_angle) && $stable(roll_angle))
		else $error("stalled item changed");
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall not tied to output backpressure");
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |-> pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868)
		else $error("clamped pitch not at half pi");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736
		&& roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736)
		else $error("angle out of range");
endmodule

bind quaternion_to_euler q2e_checker u_q2e_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
	.roll_angle(roll_angle), .pitch_clamped(pitch_clamped)
);
`default_nettype wire

@@ test/tb_top.sv @@
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_to_euler: a directed table of corner
// quaternions, then random unit and raw quaternions, with random gaps and
// output stalls. Each result is compared with a bit-accurate fixed-point
// predictor of the yaw/pitch/roll conversion, or with a directed row's known angles.
//------------------------------------------------------------------------------
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS    = 16;
	localparam int LATENCY  = 36 + STEPS;
	localparam int N_RANDOM = 1280;
	localparam longint ONE_Q30  = 64'sd1 << 30;
	localparam longint PI_Q20   = 3294199;
	localparam longint PI_Q13   = 25736;
	localparam longint HPI_Q13  = 12868;

	typedef struct {
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] roll;
		logic               clamped;
	} euler_t;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 kn_yaw;
		bit                 kn_pitch;
		logic signed [15:0] yaw;
		logic signed [14:0] pitch;
		logic               clamped;
	} quat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic in_stall, out_valid, pitch_clamped;
	logic signed [15:0] yaw_angle, roll_angle;
	logic signed [14:0] pitch_angle;

	euler_t pending_angles[$];
	int errors = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	quaternion_to_euler #(.CORDIC_STEPS(STEPS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
		.roll_angle(roll_angle), .pitch_clamped(pitch_clamped)
	);

	always #2 clk = ~clk;

	function automatic longint arc_step(input int i);
		longint tab[22] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
			8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 1};
		return (i < 22) ? tab[i] : 0;
	endfunction

	function automatic longint vector_angle(input longint sn, input longint cs);
		longint vx, vy, ang, nx;
		vx = cs;
		vy = sn;
		ang = 0;
		if (vx == 0 && vy == 0)
			return 0;
		if (vx < 0) begin
			ang = (vy >= 0) ? PI_Q20 : -PI_Q20;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (vy >= 0) begin
				nx = vx + (vy >>> i);
				vy = vy - (vx >>> i);
				ang += arc_step(i);
			end else begin
				nx = vx - (vy >>> i);
				vy = vy + (vx >>> i);
				ang -= arc_step(i);
			end
			vx = nx;
		end
		return ang;
	endfunction

	function automatic longint round_sat(input longint a, input longint lim);
		longint r;
		r = (a + 64) >>> 7;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic longint int_sqrt(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic euler_t predict_euler(input logic signed [15:0] qw, qx, qy, qz);
		longint w, x, y, z, sn, cs, r;
		euler_t e;
		w = qw; x = qx; y = qy; z = qz;
		sn = 2 * (w * y + z * x);
		cs = ONE_Q30 - 2 * (y * y + x * x);
		e.yaw = 16'(round_sat(vector_angle(sn, cs), PI_Q13));
		sn = 2 * (w * x - y * z);
		if (sn >= ONE_Q30 || sn <= -ONE_Q30) begin
			r = (sn > 0) ? HPI_Q13 : -HPI_Q13;
			e.clamped = 1'b1;
		end else begin
			cs = int_sqrt((64'd1 << 60) - longint'(sn * sn));
			r = round_sat(vector_angle(sn, cs), HPI_Q13);
			e.clamped = 1'b0;
		end
		e.pitch = 15'(r);
		sn = 2 * (w * z + x * y);
		cs = ONE_Q30 - 2 * (z * z + x * x);
		e.roll = 16'(round_sat(vector_angle(sn, cs), PI_Q13));
		return e;
	endfunction

	task automatic send_quat(input quat_row_t row);
		euler_t e;
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		quat_w = row.w; quat_x = row.x; quat_y = row.y; quat_z = row.z;
		do @(posedge clk); while (in_stall);
		e = predict_euler(row.w, row.x, row.y, row.z);
		if (row.kn_yaw) e.yaw = row.yaw;
		if (row.kn_pitch) begin
			e.pitch = row.pitch;
			e.clamped = row.clamped;
		end
		pending_angles.push_back(e);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_angles.size() != 0) @(negedge clk);
	endtask

	function automatic quat_row_t rand_quat();
		quat_row_t q;
		real a, b, c, d, n;
		int kind;
		q = '{default: '0};
		kind = $urandom_range(9);
		if (kind < 6) begin
			a = $urandom_range(20000) - 10000.0;
			b = $urandom_range(20000) - 10000.0;
			c = $urandom_range(20000) - 10000.0;
			d = $urandom_range(20000) - 10000.0;
			n = $sqrt(a * a + b * b + c * c + d * d);
			if (n < 1.0) n = 1.0;
			q.w = 16'($rtoi(a / n * 32767.0));
			q.x = 16'($rtoi(b / n * 32767.0));
			q.y = 16'($rtoi(c / n * 32767.0));
			q.z = 16'($rtoi(d / n * 32767.0));
		end else if (kind < 8) begin
			// near the pitch singularity
			q.w = 16'(23100 + $urandom_range(140));
			q.x = ($urandom_range(1)) ? 16'(23100 + $urandom_range(140))
				: -16'(23100 + $urandom_range(140));
			q.y = 16'($urandom_range(400)) - 16'sd200;
			q.z = 16'($urandom_range(400)) - 16'sd200;
		end else begin
			q.w = 16'($urandom); q.x = 16'($urandom);
			q.y = 16'($urandom); q.z = 16'($urandom);
		end
		return q;
	endfunction

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		euler_t e;
		if (out_valid && !out_stall) begin
			if (pending_angles.size() == 0) begin
				$error("result with no pending item");
				errors++;
			end else begin
				e = pending_angles.pop_front();
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle exp %0d got %0d", e.yaw, yaw_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle);
					errors++;
				end
				if (roll_angle !== e.roll) begin
					$error("roll_angle exp %0d got %0d", e.roll, roll_angle);
					errors++;
				end
				if (pitch_clamped !== e.clamped) begin
					$error("pitch_clamped exp %0b got %0b", e.clamped, pitch_clamped);
					errors++;
				end
			end
		end
	end

	initial begin
		#4ms;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		quat_row_t dir[$];
		dir = '{
			'{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 0, 0, '0, '0, '0},
			'{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd23171, 16'sd23171, 16'sd0, 16'sd0, 0, 1, '0, 15'sd12868, 1'b1},
			'{16'sd23171, -16'sd23171, 16'sd0, 16'sd0, 0, 1, '0, -15'sd12868, 1'b1},
			'{16'sd32767, 16'sd32767, 16'sd0, 16'sd0, 0, 1, '0, 15'sd12868, 1'b1},
			'{-16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 0, 1, '0, -15'sd12868, 1'b1},
			'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 1, 0, 16'sd0, '0, '0},
			'{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 0, 0, '0, '0, '0},
			'{16'sd1000, 16'sd0, -16'sd32000, 16'sd0, 0, 0, '0, '0, '0},
			'{-16'sd1000, 16'sd0, -16'sd32000, 16'sd0, 0, 0, '0, '0, '0},
			'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0, 0, '0, '0, '0},
			'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, 0, '0, '0, '0},
			'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 0, 0, '0, '0, '0},
			'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 0, 0, '0, '0, '0},
			'{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 0, 0, '0, '0, '0},
			'{16'sd0, 16'sd0, 16'sd23170, 16'sd23170, 0, 0, '0, '0, '0}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_gap_pct = 17;
		recv_stall_pct = 46;
		foreach (dir[i]) send_quat(dir[i]);
		drain();
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				send_gap_pct = 46;
				recv_stall_pct = 17;
			end else if (i == 2 * N_RANDOM / 3) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			send_quat(rand_quat());
		end
		drain();
		repeat (LATENCY + 8) @(negedge clk);
		if (errors == 0 && pending_angles.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
src/q2e_pkg.sv
src/q2e_front.sv
src/q2e_isqrt.sv
src/q2e_cordic.sv
src/quaternion_to_euler.sv
src/q2e_checker.sv
test/tb_top.sv
